### design/mpm_pkg.sv
// ---------------------------------------------------------------------------
// mpm_pkg: shared types and constants of the multi-pattern match counter
// Request and status codes, the command that travels from the front end to
// the engine, the engine state type and a saturating adder.
// ---------------------------------------------------------------------------
package mpm_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_ALPHABET_SIZE = 26;
    localparam int DEF_MAX_NODES     = 1024;

    // Fixed field widths.
    localparam int REQ_W     = 3;
    localparam int SYMBOL_W  = 8;
    localparam int SYM_IDX_W = 8;
    localparam int QNODE_W   = 16;
    localparam int COUNT_W   = 32;
    localparam int STATUS_W  = 3;

    localparam logic [SYMBOL_W-1:0] SYMBOL_BASE_RESET = 8'd97;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PATTERN = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TEXT    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADSYM  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PHASE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADNODE = 3'd4;

    // Classified request as it sits in the queue.
    typedef struct packed {
        logic [REQ_W-1:0]     req;
        logic                 sym_ok;
        logic [SYM_IDX_W-1:0] sym_idx;
        logic                 last;
        logic [QNODE_W-1:0]   qnode;
    } t_cmd;

    // Engine sequencer states.
    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_PAT,
        S_B_HEAD,
        S_B_X,
        S_B_LK,
        S_B_RD,
        S_B_WR,
        S_T_CLR,
        S_T_GO,
        S_T_INC,
        S_P_BFS,
        S_P_U,
        S_P_L,
        S_P_WR,
        S_QRY
    } t_state;

    // Unsigned add that sticks at all ones.
    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

endpackage

### design/mpm_front.sv
// ---------------------------------------------------------------------------
// mpm_front: request intake and classification
// Holds the symbol base register, maps raw bytes to symbol indexes and keeps
// a two-entry queue of classified requests for the engine.
// ---------------------------------------------------------------------------
module mpm_front
    import mpm_pkg::*;
#(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int MAX_NODES     = DEF_MAX_NODES,
    localparam int NW           = $clog2(MAX_NODES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SYMBOL_W-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [SYMBOL_W-1:0] i_symbol,
    input  logic                i_last,
    input  logic [NW-1:0]       i_node_index,
    input  logic                i_hold,
    output logic                o_q_valid,
    output t_cmd                o_cmd,
    input  logic                i_pop
);

    localparam int QD = 2;

    logic [SYMBOL_W-1:0] r_base;
    t_cmd                r_q [QD];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    logic [SYMBOL_W:0]   diff;
    t_cmd                cmd_in;
    logic                push;

    // Symbol base register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= SYMBOL_BASE_RESET;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
    end

    // Map the raw byte to an index and check it against the alphabet.
    always_comb begin
        diff           = {1'b0, i_symbol} - {1'b0, r_base};
        cmd_in.req     = i_req_type;
        cmd_in.sym_ok  = !diff[SYMBOL_W]
                         && ({1'b0, diff[SYMBOL_W-1:0]} < (SYMBOL_W+1)'(ALPHABET_SIZE));
        cmd_in.sym_idx = diff[SYMBOL_W-1:0];
        cmd_in.last    = i_last;
        cmd_in.qnode   = QNODE_W'(i_node_index);
    end

    assign o_stall   = (r_cnt == 2'(QD)) || i_hold;
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];

    // Two-entry queue between intake and engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

### design/mpm_engine.sv
// ---------------------------------------------------------------------------
// mpm_engine: automaton store and sequencer
// Owns the goto, link, depth, order and count memories and carries out one
// queued request at a time: insertion, breadth-first build, text walk with
// count propagation, queries and the clearing sweep.
// ---------------------------------------------------------------------------
module mpm_engine
    import mpm_pkg::*;
#(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int MAX_NODES     = DEF_MAX_NODES,
    localparam int NW           = $clog2(MAX_NODES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  o_sweep,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [NW-1:0]         o_node,
    output logic [COUNT_W-1:0]    o_hit_count,
    output logic [NW-1:0]         o_suffix_link,
    output logic signed [NW:0]    o_depth
);

    localparam int SW  = $clog2(ALPHABET_SIZE);
    localparam int GD  = MAX_NODES * ALPHABET_SIZE;
    localparam int GAW = $clog2(GD);
    localparam logic [NW:0] NT_MAX = (NW+1)'(MAX_NODES);

    // Memories.
    logic [NW-1:0]         goto_mem  [GD];
    logic [NW-1:0]         link_mem  [MAX_NODES];
    logic signed [NW:0]    depth_mem [MAX_NODES];
    logic [NW-1:0]         bfs_mem   [MAX_NODES];
    logic [COUNT_W-1:0]    cnt_mem   [MAX_NODES];

    logic [NW-1:0]      r_goto_a, r_goto_b, r_link_rd, r_bfs_rd;
    logic signed [NW:0] r_depth_rd;
    logic [COUNT_W-1:0] r_cnt_rd;

    // Memory ports.
    logic               goto_we;
    logic [GAW-1:0]     goto_waddr, goto_ra, goto_rb;
    logic [NW-1:0]      goto_wdata;
    logic [NW-1:0]      ga_node, gb_node, gw_node;
    logic [SW-1:0]      ga_sym, gb_sym, gw_sym;
    logic               link_we, depth_we, bfs_we, cnt_we;
    logic [NW-1:0]      link_wa, depth_wa, bfs_wa, cnt_wa;
    logic [NW-1:0]      link_ra, depth_ra, bfs_ra, cnt_ra;
    logic [NW-1:0]      link_wd, bfs_wd;
    logic signed [NW:0] depth_wd;
    logic [COUNT_W-1:0] cnt_wd;

    // Sequencer registers.
    t_state        r_state, n_state;
    logic [GAW-1:0] r_sweep, n_sweep;
    logic          r_resp, n_resp;
    logic [NW:0]   r_order_len, n_order_len;
    logic [NW:0]   r_node_total, n_node_total;
    logic          r_built, n_built;
    logic [NW-1:0] r_pcur, n_pcur;
    logic [NW-1:0] r_tcur, n_tcur;
    logic          r_topen, n_topen;
    t_cmd          r_cmd, n_cmd;
    logic [NW-1:0] r_x, n_x;
    logic [NW-1:0] r_lk, n_lk;
    logic [SW-1:0] r_i, n_i;
    logic [NW:0]   r_head, n_head;
    logic [NW:0]   r_len, n_len;
    logic [NW-1:0] r_nxt, n_nxt;
    logic [NW-1:0] r_l, n_l;
    logic [COUNT_W-1:0] r_cu, n_cu;
    logic [NW:0]   r_pi, n_pi;
    logic [NW:0]   r_ci, n_ci;

    // Result register.
    logic               r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [NW-1:0]      r_out_node, n_out_node;
    logic [COUNT_W-1:0] r_out_hits, n_out_hits;
    logic [NW-1:0]      r_out_link, n_out_link;
    logic signed [NW:0] r_out_depth, n_out_depth;

    logic          emit;
    logic [NW-1:0] base_node;
    logic [NW-1:0] newn;

    // Address generation for the goto table.
    assign goto_ra = GAW'(ga_node) * GAW'(ALPHABET_SIZE) + GAW'(ga_sym);
    assign goto_rb = GAW'(gb_node) * GAW'(ALPHABET_SIZE) + GAW'(gb_sym);

    always_comb begin
        if (r_state == S_SWEEP) begin
            goto_waddr = r_sweep;
        end else begin
            goto_waddr = GAW'(gw_node) * GAW'(ALPHABET_SIZE) + GAW'(gw_sym);
        end
    end

    // Memory arrays with registered reads.
    always_ff @(posedge i_clk) begin
        if (goto_we) begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        r_goto_a <= goto_mem[goto_ra];
        r_goto_b <= goto_mem[goto_rb];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (depth_we) begin
            depth_mem[depth_wa] <= depth_wd;
        end
        r_depth_rd <= depth_mem[depth_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bfs_we) begin
            bfs_mem[bfs_wa] <= bfs_wd;
        end
        r_bfs_rd <= bfs_mem[bfs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_rd <= cnt_mem[cnt_ra];
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep      <= '0;
            r_resp       <= 1'b0;
            r_order_len  <= '0;
            r_node_total <= (NW+1)'(2);
            r_built      <= 1'b0;
            r_pcur       <= NW'(1);
            r_tcur       <= NW'(1);
            r_topen      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_resp       <= n_resp;
            r_order_len  <= n_order_len;
            r_node_total <= n_node_total;
            r_built      <= n_built;
            r_pcur       <= n_pcur;
            r_tcur       <= n_tcur;
            r_topen      <= n_topen;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_x          <= n_x;
        r_lk         <= n_lk;
        r_i          <= n_i;
        r_head       <= n_head;
        r_len        <= n_len;
        r_nxt        <= n_nxt;
        r_l          <= n_l;
        r_cu         <= n_cu;
        r_pi         <= n_pi;
        r_ci         <= n_ci;
        r_out_status <= n_out_status;
        r_out_node   <= n_out_node;
        r_out_hits   <= n_out_hits;
        r_out_link   <= n_out_link;
        r_out_depth  <= n_out_depth;
    end

    // Next state, memory controls and result.
    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_resp       = r_resp;
        n_order_len  = r_order_len;
        n_node_total = r_node_total;
        n_built      = r_built;
        n_pcur       = r_pcur;
        n_tcur       = r_tcur;
        n_topen      = r_topen;
        n_cmd        = r_cmd;
        n_x          = r_x;
        n_lk         = r_lk;
        n_i          = r_i;
        n_head       = r_head;
        n_len        = r_len;
        n_nxt        = r_nxt;
        n_l          = r_l;
        n_cu         = r_cu;
        n_pi         = r_pi;
        n_ci         = r_ci;

        emit         = 1'b0;
        n_out_status = r_out_status;
        n_out_node   = r_out_node;
        n_out_hits   = r_out_hits;
        n_out_link   = r_out_link;
        n_out_depth  = r_out_depth;

        o_pop      = 1'b0;
        goto_we    = 1'b0;
        goto_wdata = '0;
        ga_node    = r_x;
        ga_sym     = r_i;
        gb_node    = r_lk;
        gb_sym     = r_i;
        gw_node    = r_x;
        gw_sym     = r_i;
        link_we    = 1'b0;
        link_wa    = '0;
        link_wd    = '0;
        link_ra    = '0;
        depth_we   = 1'b0;
        depth_wa   = '0;
        depth_wd   = '0;
        depth_ra   = '0;
        bfs_we     = 1'b0;
        bfs_wa     = '0;
        bfs_wd     = '0;
        bfs_ra     = '0;
        cnt_we     = 1'b0;
        cnt_wa     = '0;
        cnt_wd     = '0;
        cnt_ra     = '0;
        base_node  = r_topen ? r_tcur : NW'(1);
        newn       = r_node_total[NW-1:0];

        unique case (r_state)
            // Clearing sweep: node 0 goes to the root at depth -1, rest zero.
            S_SWEEP: begin
                goto_we    = 1'b1;
                goto_wdata = (r_sweep < GAW'(ALPHABET_SIZE)) ? NW'(1) : '0;
                if (r_sweep < GAW'(MAX_NODES)) begin
                    link_we  = 1'b1;
                    link_wa  = r_sweep[NW-1:0];
                    depth_we = 1'b1;
                    depth_wa = r_sweep[NW-1:0];
                    depth_wd = (r_sweep == '0) ? {(NW+1){1'b1}} : '0;
                    cnt_we   = 1'b1;
                    cnt_wa   = r_sweep[NW-1:0];
                end
                if (r_sweep == GAW'(GD - 1)) begin
                    n_state = S_IDLE;
                    if (r_resp) begin
                        emit         = 1'b1;
                        n_out_status = ST_OK;
                        n_out_node   = NW'(1);
                        n_resp       = 1'b0;
                    end
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end

            // Dispatch the next queued request.
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    ga_node  = r_pcur;
                    ga_sym   = i_cmd.sym_idx[SW-1:0];
                    depth_ra = r_pcur;
                    cnt_ra   = i_cmd.qnode[NW-1:0];
                    link_ra  = i_cmd.qnode[NW-1:0];
                    if (i_cmd.req == REQ_CLEAR) begin
                        n_state      = S_SWEEP;
                        n_sweep      = '0;
                        n_resp       = 1'b1;
                        n_order_len  = '0;
                        n_node_total = (NW+1)'(2);
                        n_built      = 1'b0;
                        n_pcur       = NW'(1);
                        n_tcur       = NW'(1);
                        n_topen      = 1'b0;
                    end else if (i_cmd.req == REQ_PATTERN) begin
                        if (r_built) begin
                            emit         = 1'b1;
                            n_out_status = ST_PHASE;
                            n_out_node   = r_pcur;
                        end else if (!i_cmd.sym_ok) begin
                            emit         = 1'b1;
                            n_out_status = ST_BADSYM;
                            n_out_node   = r_pcur;
                        end else begin
                            n_state = S_PAT;
                        end
                    end else if (i_cmd.req == REQ_BUILD) begin
                        if (r_built) begin
                            emit         = 1'b1;
                            n_out_status = ST_OK;
                            n_out_node   = NW'(1);
                        end else begin
                            bfs_we  = 1'b1;
                            bfs_wa  = '0;
                            bfs_wd  = NW'(1);
                            n_len   = (NW+1)'(1);
                            n_head  = '0;
                            n_state = S_B_HEAD;
                        end
                    end else if (i_cmd.req == REQ_TEXT) begin
                        if (!r_built) begin
                            emit         = 1'b1;
                            n_out_status = ST_PHASE;
                            n_out_node   = base_node;
                        end else if (!i_cmd.sym_ok) begin
                            emit         = 1'b1;
                            n_out_status = ST_BADSYM;
                            n_out_node   = base_node;
                        end else if (!r_topen) begin
                            n_ci    = '0;
                            n_state = S_T_CLR;
                        end else begin
                            ga_node = r_tcur;
                            n_state = S_T_GO;
                        end
                    end else if (i_cmd.req == REQ_QUERY) begin
                        depth_ra = i_cmd.qnode[NW-1:0];
                        if ((QNODE_W+1)'(i_cmd.qnode) >= (QNODE_W+1)'(r_node_total)) begin
                            emit         = 1'b1;
                            n_out_status = ST_BADNODE;
                            n_out_node   = i_cmd.qnode[NW-1:0];
                        end else begin
                            n_state = S_QRY;
                        end
                    end else begin
                        emit         = 1'b1;
                        n_out_status = ST_PHASE;
                        n_out_node   = '0;
                    end
                end
            end

            // Pattern symbol: follow or create the child.
            S_PAT: begin
                gw_node      = r_pcur;
                gw_sym       = r_cmd.sym_idx[SW-1:0];
                emit         = 1'b1;
                n_out_status = ST_OK;
                n_state      = S_IDLE;
                if (r_goto_a == '0) begin
                    if (r_node_total == NT_MAX) begin
                        n_out_status = ST_FULL;
                        n_out_node   = r_pcur;
                    end else begin
                        goto_we      = 1'b1;
                        goto_wdata   = newn;
                        depth_we     = 1'b1;
                        depth_wa     = newn;
                        depth_wd     = r_depth_rd + $signed((NW+1)'(1));
                        n_node_total = r_node_total + 1'b1;
                        n_out_node   = newn;
                        n_pcur       = r_cmd.last ? NW'(1) : newn;
                    end
                end else begin
                    n_out_node = r_goto_a;
                    n_pcur     = r_cmd.last ? NW'(1) : r_goto_a;
                end
            end

            // Build: pop the next node of the breadth-first order.
            S_B_HEAD: begin
                bfs_ra  = r_head[NW-1:0];
                n_state = S_B_X;
            end

            S_B_X: begin
                n_x     = r_bfs_rd;
                link_ra = r_bfs_rd;
                n_head  = r_head + 1'b1;
                n_state = S_B_LK;
            end

            S_B_LK: begin
                n_lk    = r_link_rd;
                n_i     = '0;
                n_state = S_B_RD;
            end

            S_B_RD: begin
                n_state = S_B_WR;
            end

            // Build: fill a missing edge or link and enqueue a child.
            S_B_WR: begin
                if (r_goto_a == '0) begin
                    goto_we    = 1'b1;
                    goto_wdata = r_goto_b;
                end else if (r_len < NT_MAX) begin
                    link_we = 1'b1;
                    link_wa = r_goto_a;
                    link_wd = r_goto_b;
                    bfs_we  = 1'b1;
                    bfs_wa  = r_len[NW-1:0];
                    bfs_wd  = r_goto_a;
                    n_len   = r_len + 1'b1;
                end
                if (r_i == SW'(ALPHABET_SIZE - 1)) begin
                    if (r_head < n_len) begin
                        n_state = S_B_HEAD;
                    end else begin
                        n_order_len  = n_len;
                        n_built      = 1'b1;
                        n_pcur       = NW'(1);
                        emit         = 1'b1;
                        n_out_status = ST_OK;
                        n_out_node   = NW'(1);
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_B_RD;
                end
            end

            // Start of text: zero the counts of all live nodes.
            S_T_CLR: begin
                cnt_we = 1'b1;
                cnt_wa = r_ci[NW-1:0];
                if (r_ci == r_node_total - 1'b1) begin
                    n_tcur  = NW'(1);
                    n_topen = 1'b1;
                    ga_node = NW'(1);
                    ga_sym  = r_cmd.sym_idx[SW-1:0];
                    n_state = S_T_GO;
                end else begin
                    n_ci = r_ci + 1'b1;
                end
            end

            S_T_GO: begin
                n_nxt   = r_goto_a;
                cnt_ra  = r_goto_a;
                n_state = S_T_INC;
            end

            // Text step: count the visit, then push counts on the last symbol.
            S_T_INC: begin
                cnt_we = 1'b1;
                cnt_wa = r_nxt;
                cnt_wd = sat_add(r_cnt_rd, COUNT_W'(1));
                n_tcur = r_nxt;
                if (r_cmd.last && (r_order_len > (NW+1)'(1))) begin
                    n_topen = 1'b0;
                    n_pi    = r_order_len;
                    n_state = S_P_BFS;
                end else begin
                    if (r_cmd.last) begin
                        n_topen = 1'b0;
                    end
                    emit         = 1'b1;
                    n_out_status = ST_OK;
                    n_out_node   = r_nxt;
                    n_state      = S_IDLE;
                end
            end

            S_P_BFS: begin
                bfs_ra  = r_pi[NW-1:0] - 1'b1;
                n_state = S_P_U;
            end

            S_P_U: begin
                link_ra = r_bfs_rd;
                cnt_ra  = r_bfs_rd;
                n_state = S_P_L;
            end

            S_P_L: begin
                n_l     = r_link_rd;
                n_cu    = r_cnt_rd;
                cnt_ra  = r_link_rd;
                n_state = S_P_WR;
            end

            S_P_WR: begin
                cnt_we = 1'b1;
                cnt_wa = r_l;
                cnt_wd = sat_add(r_cnt_rd, r_cu);
                n_pi   = r_pi - 1'b1;
                if (r_pi > (NW+1)'(2)) begin
                    n_state = S_P_BFS;
                end else begin
                    emit         = 1'b1;
                    n_out_status = ST_OK;
                    n_out_node   = r_tcur;
                    n_state      = S_IDLE;
                end
            end

            // Query: the reads were issued at dispatch.
            S_QRY: begin
                emit         = 1'b1;
                n_out_status = ST_OK;
                n_out_node   = r_cmd.qnode[NW-1:0];
                n_out_hits   = r_cnt_rd;
                n_out_link   = r_link_rd;
                n_out_depth  = r_depth_rd;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Fields that only a good query fills.
        if (emit && (r_state != S_QRY)) begin
            n_out_hits  = '0;
            n_out_link  = '0;
            n_out_depth = '0;
        end

        // Result register handshake.
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_sweep       = (r_state == S_SWEEP);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_node        = r_out_node;
    assign o_hit_count   = r_out_hits;
    assign o_suffix_link = r_out_link;
    assign o_depth       = r_out_depth;

endmodule

### design/multi_pattern_match_counter.sv
// ---------------------------------------------------------------------------
// multi_pattern_match_counter: multi-pattern matcher with occurrence counts
// Front end classifies requests into a short queue; the engine inserts
// patterns, builds the automaton, walks text and answers node queries.
// ---------------------------------------------------------------------------
//
//   channel | handshake           | beat contents
//   --------+---------------------+--------------------------------------------
//   in      | i_valid / o_stall   | req_type, symbol, last, node_index
//   out     | o_valid / i_stall   | status, node, hit_count, suffix_link, depth
//   cfg     | i_cfg_we            | symbol_base
//
// Errors answer at dispatch, queries from S_QRY and pattern symbols from S_PAT.
// A text symbol is walked and counted, after counts are zeroed as a text opens;
// a last one pushes counts along suffix links in reverse breadth-first order.
// Build visits every node and its symbols, paced by the goto memory. After
// reset and on a clear beat a sweep of all MAX_NODES*ALPHABET_SIZE goto entries
// clears the goto table; no input beat is taken during it. The next request
// starts the cycle after its predecessor's result leaves; the queue takes two.
// ---------------------------------------------------------------------------
module multi_pattern_match_counter
    import mpm_pkg::*;
#(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int MAX_NODES     = DEF_MAX_NODES,
    localparam int NW           = $clog2(MAX_NODES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SYMBOL_W-1:0]   i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [SYMBOL_W-1:0]   i_symbol,
    input  logic                  i_last,
    input  logic [NW-1:0]         i_node_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [NW-1:0]         o_node,
    output logic [COUNT_W-1:0]    o_hit_count,
    output logic [NW-1:0]         o_suffix_link,
    output logic signed [NW:0]    o_depth
);

    logic q_valid;
    t_cmd q_cmd;
    logic pop;
    logic sweep;

    // Intake and classification.
    mpm_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_NODES     (MAX_NODES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_symbol     (i_symbol),
        .i_last       (i_last),
        .i_node_index (i_node_index),
        .i_hold       (sweep),
        .o_q_valid    (q_valid),
        .o_cmd        (q_cmd),
        .i_pop        (pop)
    );

    // Automaton engine.
    mpm_engine #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_NODES     (MAX_NODES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (pop),
        .o_sweep       (sweep),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_node        (o_node),
        .o_hit_count   (o_hit_count),
        .o_suffix_link (o_suffix_link),
        .o_depth       (o_depth)
    );

    // The engine only takes a queued beat that exists.
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("engine popped an empty queue");

    // A new request starts only once the previous result has left.
    a_pop_needs_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !o_valid)
        else $error("engine popped while a result was waiting");

    // The sweep never starts a request.
    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep |-> !pop)
        else $error("request taken during the clearing sweep");

endmodule

### sim/multi_pattern_match_counter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_pattern_match_counter_tb: self-checking bench for the pattern matcher
// A directed table covers error codes, phase rules and the first automaton,
// then random phases insert patterns, build, stream text and query nodes
// under several symbol bases, with one phase that fills the node store.
// Each result beat is checked against a typed-in value or an automaton model.
// ---------------------------------------------------------------------------
module multi_pattern_match_counter_tb;
    import mpm_pkg::*;

    localparam int ALPHA      = DEF_ALPHABET_SIZE;
    localparam int NODES      = DEF_MAX_NODES;
    localparam int NW         = $clog2(NODES);
    localparam int WD_LIMIT   = 300000;
    localparam int RAND_ITEMS = 1500;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NW-1:0]       node;
        logic [COUNT_W-1:0]  hits;
        logic [NW-1:0]       link;
        logic [NW:0]         depth;
    } match_result_t;

    typedef struct {
        logic [REQ_W-1:0]    req;
        logic [SYMBOL_W-1:0] sym;
        logic                last;
        logic [NW-1:0]       qn;
        bit                  typed;
        match_result_t       res;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [SYMBOL_W-1:0]   i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [REQ_W-1:0]      i_req_type = '0;
    logic [SYMBOL_W-1:0]   i_symbol = '0;
    logic                  i_last = 1'b0;
    logic [NW-1:0]         i_node_index = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [NW-1:0]         o_node;
    logic [COUNT_W-1:0]    o_hit_count;
    logic [NW-1:0]         o_suffix_link;
    logic signed [NW:0]    o_depth;

    multi_pattern_match_counter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_symbol(i_symbol), .i_last(i_last),
        .i_node_index(i_node_index),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_node(o_node), .o_hit_count(o_hit_count),
        .o_suffix_link(o_suffix_link), .o_depth(o_depth)
    );

    always #5 i_clk = ~i_clk;

    // Automaton mirror.
    int unsigned   sym_base;
    int unsigned   trans_tbl[NODES*ALPHA];
    int unsigned   fail_link[NODES];
    int            node_depth[NODES];
    int unsigned   walk_order[NODES];
    int unsigned   walk_len;
    int unsigned   nodes_used;
    bit            built;
    int unsigned   pat_pos;
    int unsigned   txt_pos;
    bit            txt_open;
    int unsigned   hit_tally[NODES];

    match_result_t pending_results[$];
    int            err_count = 0;
    bit            calm = 1'b0;
    bit            hold_req = 1'b0;
    int            full_seen = 0;

    function automatic int unsigned sat_inc(int unsigned a, int unsigned b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(s);
    endfunction

    function automatic void wipe_automaton();
        foreach (trans_tbl[i]) trans_tbl[i] = (i < ALPHA) ? 1 : 0;
        foreach (fail_link[i]) begin
            fail_link[i] = 0;
            node_depth[i] = 0;
            hit_tally[i] = 0;
        end
        node_depth[0] = -1;
        walk_len = 0;
        nodes_used = 2;
        built = 1'b0;
        pat_pos = 1;
        txt_pos = 1;
        txt_open = 1'b0;
    endfunction

    function automatic int symbol_slot(logic [SYMBOL_W-1:0] raw);
        int x;
        x = int'(raw) - int'(sym_base);
        return (x < 0 || x >= ALPHA) ? -1 : x;
    endfunction

    // Breadth-first pass: suffix links, completed transitions, visit order.
    function automatic void build_links();
        int unsigned head, x, lk, ch, via;
        head = 0;
        walk_len = 0;
        walk_order[walk_len++] = 1;
        while (head < walk_len) begin
            x = walk_order[head++];
            lk = fail_link[x];
            for (int i = 0; i < ALPHA; i++) begin
                ch = trans_tbl[x*ALPHA+i];
                via = trans_tbl[lk*ALPHA+i];
                if (ch == 0) begin
                    trans_tbl[x*ALPHA+i] = via;
                end else if (walk_len < NODES) begin
                    fail_link[ch] = via;
                    walk_order[walk_len++] = ch;
                end
            end
        end
        built = 1'b1;
        pat_pos = 1;
    endfunction

    // Applies one request to the mirror and returns its result beat.
    function automatic match_result_t match_step(logic [REQ_W-1:0] req,
                                                 logic [SYMBOL_W-1:0] sym,
                                                 logic last, logic [NW-1:0] qn);
        match_result_t r;
        int x;
        int unsigned slot, ch, u, l;
        r = '0;
        case (req)
            REQ_CLEAR: begin
                wipe_automaton();
                r.node = NW'(1);
            end
            REQ_PATTERN: begin
                r.node = NW'(pat_pos);
                x = symbol_slot(sym);
                if (built) begin
                    r.status = ST_PHASE;
                end else if (x < 0) begin
                    r.status = ST_BADSYM;
                end else begin
                    slot = pat_pos*ALPHA + x;
                    ch = trans_tbl[slot];
                    if (ch == 0 && nodes_used >= NODES) begin
                        r.status = ST_FULL;
                    end else begin
                        if (ch == 0) begin
                            ch = nodes_used++;
                            trans_tbl[slot] = ch;
                            node_depth[ch] = node_depth[pat_pos] + 1;
                        end
                        r.node = NW'(ch);
                        pat_pos = last ? 1 : ch;
                    end
                end
            end
            REQ_BUILD: begin
                if (!built) build_links();
                r.node = NW'(1);
            end
            REQ_TEXT: begin
                r.node = NW'(txt_open ? txt_pos : 1);
                x = symbol_slot(sym);
                if (!built) begin
                    r.status = ST_PHASE;
                end else if (x < 0) begin
                    r.status = ST_BADSYM;
                end else begin
                    if (!txt_open) begin
                        foreach (hit_tally[i]) hit_tally[i] = 0;
                        txt_pos = 1;
                        txt_open = 1'b1;
                    end
                    txt_pos = trans_tbl[txt_pos*ALPHA + x];
                    hit_tally[txt_pos] = sat_inc(hit_tally[txt_pos], 1);
                    r.node = NW'(txt_pos);
                    // Push counts to suffix links, deepest nodes first.
                    if (last) begin
                        for (int i = walk_len; i > 1; i--) begin
                            u = walk_order[i-1];
                            l = fail_link[u];
                            hit_tally[l] = sat_inc(hit_tally[l], hit_tally[u]);
                        end
                        txt_open = 1'b0;
                    end
                end
            end
            REQ_QUERY: begin
                r.node = qn;
                if (qn >= nodes_used) begin
                    r.status = ST_BADNODE;
                end else begin
                    r.hits = hit_tally[qn];
                    r.link = NW'(fail_link[qn]);
                    r.depth = (NW+1)'(node_depth[qn]);
                end
            end
            default: r.status = ST_PHASE;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one beat, waits for it to be taken and records its result.
    task automatic send_beat(input logic [REQ_W-1:0] req, input logic [SYMBOL_W-1:0] sym,
                             input logic last, input logic [NW-1:0] qn,
                             input bit typed = 1'b0, input match_result_t want = '0);
        int gap;
        match_result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_symbol <= sym;
        i_last <= last;
        i_node_index <= qn;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = match_step(req, sym, last, qn);
        if (r.status == ST_FULL) full_seen++;
        pending_results.insert(pending_results.size(), typed ? want : r);
    endtask

    // Lets every result drain, then leaves the block some idle cycles.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [SYMBOL_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sym_base = v;
    endtask

    function automatic logic [SYMBOL_W-1:0] pick_sym(int span);
        return SYMBOL_W'(sym_base + $urandom_range(0, span - 1));
    endfunction

    // One random session: patterns, build, text streams and queries.
    task automatic run_session(inout int sent);
        int npat, len, span, ntxt;
        logic [SYMBOL_W-1:0] s;
        span = ($urandom_range(0, 3) == 0) ? ALPHA : 3;
        if ($urandom_range(0, 9) != 0) begin
            send_beat(REQ_CLEAR, 8'($urandom), 1'($urandom), NW'($urandom));
            sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_beat(REQ_TEXT, pick_sym(span), 1'($urandom), NW'($urandom));
            sent++;
        end
        npat = $urandom_range(3, 9);
        for (int p = 0; p < npat; p++) begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) begin
                s = ($urandom_range(0, 14) == 0) ? 8'($urandom) : pick_sym(span);
                send_beat(REQ_PATTERN, s, j == len - 1, NW'($urandom));
                sent++;
                if ($urandom_range(0, 19) == 0) begin
                    send_beat($urandom_range(0, 1) ? REQ_UNKNOWN : 3'($urandom_range(5, 7)),
                              8'($urandom), 1'($urandom), NW'($urandom));
                    sent++;
                end
            end
        end
        // Occasionally leave a pattern unfinished across the build.
        if ($urandom_range(0, 5) == 0) begin
            send_beat(REQ_PATTERN, pick_sym(span), 1'b0, NW'($urandom));
            sent++;
        end
        send_beat(REQ_BUILD, 8'($urandom), 1'($urandom), NW'($urandom));
        sent++;
        if ($urandom_range(0, 3) == 0) begin
            send_beat(REQ_BUILD, 8'($urandom), 1'($urandom), NW'($urandom));
            send_beat(REQ_PATTERN, pick_sym(span), 1'($urandom), NW'($urandom));
            sent += 2;
        end
        ntxt = $urandom_range(3, 6);
        for (int t = 0; t < ntxt; t++) begin
            len = $urandom_range(1, 20);
            for (int j = 0; j < len; j++) begin
                s = ($urandom_range(0, 11) == 0) ? 8'($urandom) : pick_sym(span);
                send_beat(REQ_TEXT, s, j == len - 1, NW'($urandom));
                sent++;
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(REQ_QUERY, 8'($urandom), 1'($urandom),
                              NW'($urandom_range(0, nodes_used - 1)));
                    sent++;
                end
            end
        end
        for (int q = 0; q < 8; q++) begin
            send_beat(REQ_QUERY, 8'($urandom), 1'($urandom), (q == 7) ? NW'($urandom) :
                      NW'($urandom_range(0, nodes_used - 1)));
            sent++;
        end
    endtask

    // Fills the store with long patterns to four full reports, then uses it.
    task automatic fill_store(inout int sent);
        int len;
        send_beat(REQ_CLEAR, 8'd0, 1'b0, NW'(0));
        sent++;
        while (full_seen < 4) begin
            len = $urandom_range(1, 40);
            for (int j = 0; j < len; j++) begin
                send_beat(REQ_PATTERN, pick_sym(ALPHA), j == len - 1, NW'($urandom));
                sent++;
            end
        end
        send_beat(REQ_BUILD, 8'd0, 1'b0, NW'(0));
        sent++;
        for (int j = 0; j < 30; j++) begin
            send_beat(REQ_TEXT, pick_sym(ALPHA), j == 29, NW'($urandom));
            sent++;
        end
        for (int q = 0; q < 40; q++) begin
            send_beat(REQ_QUERY, 8'($urandom), 1'($urandom), NW'($urandom));
            sent++;
        end
    endtask

    // Result side: checks beats and decides the stall for the next cycle.
    initial begin
        int hold_left;
        match_result_t got, want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = '{o_status, o_node, o_hit_count, o_suffix_link, o_depth};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, got);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        err_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (pick_gap() > 0);
            end
        end
    end

    // Watchdog on cycles without any beat moving.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t dir_rows[$];
        logic [SYMBOL_W-1:0] base_plan[4];
        int sent;
        base_plan = '{8'd0, 8'd255, 8'd230, 8'd97};
        sym_base = SYMBOL_BASE_RESET;
        wipe_automaton();

        // Directed rows; results typed in where they are obvious.
        dir_rows = '{
            '{REQ_QUERY,   8'd0,   1'b0, 10'd0,    1, '{ST_OK, 10'd0, 32'd0, 10'd0, 11'h7FF}},
            '{REQ_QUERY,   8'd0,   1'b0, 10'd1023, 1, '{ST_BADNODE, 10'd1023, 0, 0, 0}},
            '{REQ_TEXT,    8'd97,  1'b1, 10'd0,    1, '{ST_PHASE, 10'd1, 0, 0, 0}},
            '{REQ_UNKNOWN, 8'd97,  1'b1, 10'd5,    1, '{ST_PHASE, 10'd0, 0, 0, 0}},
            '{3'd5,        8'd255, 1'b0, 10'd1023, 1, '{ST_PHASE, 10'd0, 0, 0, 0}},
            '{3'd6,        8'd0,   1'b1, 10'd0,    1, '{ST_PHASE, 10'd0, 0, 0, 0}},
            '{REQ_PATTERN, 8'd255, 1'b1, 10'd0,    1, '{ST_BADSYM, 10'd1, 0, 0, 0}},
            '{REQ_PATTERN, 8'd97,  1'b0, 10'd0,    1, '{ST_OK, 10'd2, 0, 0, 0}},
            '{REQ_PATTERN, 8'd98,  1'b1, 10'd0,    1, '{ST_OK, 10'd3, 0, 0, 0}},
            '{REQ_PATTERN, 8'd98,  1'b1, 10'd0,    1, '{ST_OK, 10'd4, 0, 0, 0}},
            '{REQ_PATTERN, 8'd0,   1'b1, 10'd0,    1, '{ST_BADSYM, 10'd1, 0, 0, 0}},
            '{REQ_PATTERN, 8'd122, 1'b0, 10'd0,    1, '{ST_OK, 10'd5, 0, 0, 0}},
            '{REQ_BUILD,   8'd0,   1'b0, 10'd0,    1, '{ST_OK, 10'd1, 0, 0, 0}},
            '{REQ_PATTERN, 8'd97,  1'b1, 10'd0,    1, '{ST_PHASE, 10'd1, 0, 0, 0}},
            '{REQ_BUILD,   8'd0,   1'b0, 10'd0,    1, '{ST_OK, 10'd1, 0, 0, 0}},
            '{REQ_TEXT,    8'd97,  1'b0, 10'd0,    0, '0},
            '{REQ_TEXT,    8'd128, 1'b1, 10'd0,    0, '0},
            '{REQ_QUERY,   8'd0,   1'b0, 10'd2,    0, '0},
            '{REQ_TEXT,    8'd98,  1'b1, 10'd0,    0, '0},
            '{REQ_QUERY,   8'd0,   1'b0, 10'd3,    0, '0},
            '{REQ_QUERY,   8'd0,   1'b0, 10'd4,    0, '0},
            '{REQ_QUERY,   8'd0,   1'b0, 10'd1,    0, '0},
            '{REQ_TEXT,    8'd122, 1'b1, 10'd0,    0, '0},
            '{REQ_CLEAR,   8'd0,   1'b0, 10'd0,    1, '{ST_OK, 10'd1, 0, 0, 0}},
            '{REQ_QUERY,   8'd0,   1'b0, 10'd2,    1, '{ST_BADNODE, 10'd2, 0, 0, 0}}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_base(SYMBOL_BASE_RESET);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].req, dir_rows[i].sym, dir_rows[i].last,
                      dir_rows[i].qn, dir_rows[i].typed, dir_rows[i].res);

        // Random sessions, each under its own symbol base. The fill phase uses
        // the full alphabet so that the store can actually run out of nodes.
        sent = 0;
        for (int k = 0; sent < RAND_ITEMS; k++) begin
            drain();
            write_base((k < 4) ? base_plan[k] :
                       ((k == 4) ? SYMBOL_BASE_RESET : 8'($urandom)));
            calm = (k % 5 == 4);
            if (k == 2) hold_req = 1'b1;
            if (k == 4) fill_store(sent);
            run_session(sent);
        end

        drain();
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
